// ===== sv/spwm_pkg.sv =====
// shared types, constants and register codes for the sinusoidal pwm blanking block
// no dependencies
`default_nettype none
package spwm_pkg;
    localparam int CHANNELS_DEF = 6;
    localparam int SINE_ENTRIES_DEF = 1024;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_HALF = 64'd536870912;
    localparam int unsigned TAYLOR_DIV [6] = '{6, 20, 42, 72, 110, 156};

    localparam int IN_W = 48;
    localparam int OUT_W = 24;

    typedef enum logic [1:0] {
        REG_PERIOD = 2'd0,
        REG_MAX_MOD = 2'd1,
        REG_PHASE_STEP = 2'd2,
        REG_BLANKING = 2'd3
    } t_reg;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PHASE = 6'b000010,
        ST_ROM = 6'b000100,
        ST_DUTY = 6'b001000,
        ST_CMP = 6'b010000,
        ST_DECIDE = 6'b100000
    } t_state;

    typedef struct packed {
        logic load;
        logic phase;
        logic rom;
        logic duty;
        logic cmp;
        logic decide;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;
endpackage
`default_nettype wire

// ===== sv/spwm_sine_rom.sv =====
// quarter-wave sine magnitude table with registered read
// depends on spwm_pkg for the series constants
`default_nettype none
module spwm_sine_rom
    import spwm_pkg::*;
#(
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEF,
    parameter int AW = $clog2(SINE_ENTRIES)
) (
    input  wire logic          i_clk,
    input  wire logic [AW-1:0] i_addr,
    output logic      [15:0]   o_data
);
    // taylor series through x^13 in unsigned q30, evaluated at elaboration
    function automatic logic [15:0] f_sine(input int unsigned k);
        logic [63:0] x;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] mag;
        x = (64'(k) * HALF_PI_Q30) / SINE_ENTRIES;
        sum = x;
        term = x;
        for (int n = 1; n <= 6; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TAYLOR_DIV[n-1];
            if (n % 2 == 1) begin
                sum = (term > sum) ? 64'd0 : sum - term;
            end else begin
                sum = sum + term;
            end
        end
        mag = (sum * 64'd65535 + Q30_HALF) >> 30;
        return (mag > 64'd65535) ? 16'hFFFF : mag[15:0];
    endfunction

    logic [15:0] w_rom [SINE_ENTRIES];

    for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_rom
        localparam logic [15:0] VAL = f_sine(k);
        assign w_rom[k] = VAL;
    end

    always_ff @(posedge i_clk) begin
        o_data <= w_rom[i_addr];
    end
endmodule
`default_nettype wire

// ===== sv/spwm_ctrl.sv =====
// sequencing state machine: load, phase, table read, duty, compare, decide
// depends on spwm_pkg
`default_nettype none
module spwm_ctrl
    import spwm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);
    t_state r_state, n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_PHASE;
                end
            end
            ST_PHASE: begin
                o_cmd.phase = 1'b1;
                n_state = ST_ROM;
            end
            ST_ROM: begin
                o_cmd.rom = 1'b1;
                n_state = ST_DUTY;
            end
            ST_DUTY: begin
                o_cmd.duty = 1'b1;
                n_state = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                // hold until the output register can take the result
                if (i_status.out_free) begin
                    o_cmd.decide = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

// ===== sv/spwm_dp.sv =====
// datapath: config registers, phase accumulator, duty math, channel state, output register
// depends on spwm_pkg and spwm_sine_rom
`default_nettype none
module spwm_dp
    import spwm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [31:0]      i_cfg_data,
    input  wire logic [IN_W-1:0]  i_in_data,
    input  wire logic             i_in_first,
    input  wire t_cmd             i_cmd,
    output t_status               o_status,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output logic [OUT_W-1:0]      o_out_data
);
    localparam int AW = $clog2(SINE_ENTRIES);
    localparam int PW = 30 + AW + 2;
    localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [15:0] r_period, r_max_mod;
    logic [31:0] r_phase_step;
    logic [19:0] r_blanking;

    // registered item
    logic [19:0] r_dt;
    logic        r_first, r_gen, r_present, r_cen, r_fault, r_commit;
    logic [2:0]  r_ch;
    logic [15:0] r_mi;
    logic [31:0] r_prod;
    logic [31:0] r_phase;
    logic [15:0] r_duty;
    logic [15:0] r_cmp;
    logic [15:0] w_mag;

    logic [CHANNELS-1:0] r_en, r_dir, r_blank, r_pend;
    logic signed [20:0]  r_left [CHANNELS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 16'd500;
            r_max_mod <= 16'd62259;
            r_phase_step <= 32'd214748;
            r_blanking <= 20'd1000;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_idx))
                REG_PERIOD: r_period <= i_cfg_data[15:0];
                REG_MAX_MOD: r_max_mod <= i_cfg_data[15:0];
                REG_PHASE_STEP: r_phase_step <= i_cfg_data;
                REG_BLANKING: r_blanking <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dt <= i_in_data[19:0];
            r_gen <= i_in_data[20];
            r_ch <= i_in_data[23:21];
            r_present <= i_in_data[24];
            r_cen <= i_in_data[25];
            r_fault <= i_in_data[26];
            r_mi <= i_in_data[42:27];
            r_commit <= i_in_data[43];
            r_first <= i_in_first;
            r_prod <= 32'(r_phase_step * 52'(i_in_data[19:0]));
        end
    end

    // table address from the quarter position
    logic [29:0]   w_pos;
    logic [PW-1:0] w_idx_full;
    logic [AW-1:0] w_addr;
    assign w_pos = r_phase[30] ? (30'h3FFFFFFF - r_phase[29:0]) : r_phase[29:0];
    assign w_idx_full = PW'(w_pos) * PW'(SINE_ENTRIES);
    assign w_addr = AW'(w_idx_full >> 30);

    spwm_sine_rom #(.SINE_ENTRIES(SINE_ENTRIES), .AW(AW)) u_rom (
        .i_clk (i_clk),
        .i_addr(w_addr),
        .o_data(w_mag)
    );

    logic        w_enable;
    logic [31:0] w_mul;
    logic [15:0] w_duty_raw;
    logic [31:0] w_cmp_mul;
    assign w_enable = r_gen && r_cen && !r_fault && (r_mi != 16'd0);
    assign w_mul = r_mi * w_mag;
    assign w_duty_raw = w_enable ? w_mul[31:16] : 16'd0;
    assign w_cmp_mul = r_duty * r_period;

    always_ff @(posedge i_clk) begin
        if (i_cmd.duty) begin
            r_duty <= (w_duty_raw > r_max_mod) ? r_max_mod : w_duty_raw;
        end
        if (i_cmd.cmp) begin
            r_cmp <= w_cmp_mul[31:16];
        end
    end

    // decision for the current channel
    logic [CIW-1:0]     w_cidx;
    logic               w_in_range, w_pos_half;
    logic               w_clear_all, w_clear_ch, w_write;
    logic               w_en_n, w_dir_n, w_blank_n, w_pend_n;
    logic signed [20:0] w_left_n, w_left_dec;
    logic [15:0]        w_o_cmp;
    logic               w_o_forced, w_o_dir, w_o_stage, w_o_blank;

    assign w_cidx = CIW'(r_ch);
    assign w_in_range = (32'(r_ch) < CHANNELS);
    assign w_pos_half = !r_phase[31];

    always_comb begin
        w_clear_all = 1'b0;
        w_clear_ch = 1'b0;
        w_write = 1'b0;
        w_en_n = r_en[w_cidx];
        w_dir_n = r_dir[w_cidx];
        w_blank_n = r_blank[w_cidx];
        w_pend_n = r_pend[w_cidx];
        w_left_n = r_left[w_cidx];
        w_left_dec = '0;
        w_o_cmp = 16'd0;
        w_o_forced = 1'b1;
        w_o_dir = 1'b0;
        w_o_stage = 1'b0;
        w_o_blank = 1'b0;
        if (r_dt == 20'd0) begin
            w_clear_all = 1'b1;
        end else if (!w_in_range || !r_present) begin
            w_write = 1'b0;
        end else if (!w_enable || r_cmp == 16'd0 || r_cmp >= r_period) begin
            w_clear_ch = 1'b1;
        end else begin
            w_write = 1'b1;
            if (r_blank[w_cidx]) begin
                if (w_pos_half != r_pend[w_cidx]) begin
                    w_pend_n = w_pos_half;
                    w_left_dec = $signed({1'b0, r_blanking}) - $signed({1'b0, r_dt});
                end else begin
                    w_left_dec = r_left[w_cidx] - $signed({1'b0, r_dt});
                end
                w_left_n = w_left_dec;
                if (w_left_dec > 21'sd0) begin
                    w_en_n = 1'b0;
                    w_o_dir = r_dir[w_cidx];
                    w_o_blank = 1'b1;
                end else if (!r_en[w_cidx] && !r_commit) begin
                    w_clear_ch = 1'b1;
                    w_write = 1'b0;
                end else begin
                    w_dir_n = w_pend_n;
                    w_en_n = 1'b1;
                    w_blank_n = 1'b0;
                end
            end else if (r_en[w_cidx] && w_pos_half != r_dir[w_cidx]) begin
                // half wave changed: hold old direction while blanking
                w_pend_n = w_pos_half;
                w_left_n = $signed({1'b0, r_blanking});
                w_en_n = 1'b0;
                w_blank_n = 1'b1;
                w_o_dir = r_dir[w_cidx];
                w_o_blank = 1'b1;
            end else if (!r_en[w_cidx] && !r_commit) begin
                w_clear_ch = 1'b1;
                w_write = 1'b0;
            end else begin
                w_dir_n = w_pos_half;
                w_en_n = 1'b1;
                w_blank_n = 1'b0;
            end
            if (w_write && w_en_n) begin
                w_o_cmp = r_cmp;
                w_o_forced = 1'b0;
                w_o_dir = w_dir_n;
                w_o_stage = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_en <= '0;
            r_dir <= '0;
            r_blank <= '0;
            r_pend <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_left[c] <= '0;
            end
        end else begin
            if (i_cmd.phase && r_first && r_dt != 20'd0) begin
                r_phase <= r_phase + r_prod;
            end
            if (i_cmd.decide) begin
                if (w_clear_all) begin
                    r_en <= '0;
                    r_dir <= '0;
                    r_blank <= '0;
                    r_pend <= '0;
                    for (int c = 0; c < CHANNELS; c++) begin
                        r_left[c] <= '0;
                    end
                end else if (w_clear_ch) begin
                    r_en[w_cidx] <= 1'b0;
                    r_dir[w_cidx] <= 1'b0;
                    r_blank[w_cidx] <= 1'b0;
                    r_pend[w_cidx] <= 1'b0;
                    r_left[w_cidx] <= '0;
                end else if (w_write) begin
                    r_en[w_cidx] <= w_en_n;
                    r_dir[w_cidx] <= w_dir_n;
                    r_blank[w_cidx] <= w_blank_n;
                    r_pend[w_cidx] <= w_pend_n;
                    r_left[w_cidx] <= w_left_n;
                end
            end
        end
    end

    // output register
    assign o_status.out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.decide) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            o_out_data <= {1'b0, w_o_blank, w_o_stage, w_o_dir, w_o_forced, w_o_cmp, r_ch};
        end
    end

    a_no_en_in_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_en & r_blank) == '0)
        else $error("channel enabled while blanking");
    a_invalid_tick_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.decide && r_dt == 20'd0) |=> (r_en == '0 && r_blank == '0))
        else $error("invalid tick did not clear channels");
    a_stage_has_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data[21]) |-> (o_out_data[18:3] != 16'd0 && !o_out_data[19]))
        else $error("active stage with zero compare or forced low");
endmodule
`default_nettype wire

// ===== sv/spwm_channel_blanking.sv =====
// top level of the sinusoidal pwm generator with direction change blanking
// depends on spwm_pkg, spwm_ctrl, spwm_dp
`default_nettype none
// One channel request is taken per item and gives one result item. An item
// reaches the result register in these steps: phase multiply at the accepting
// edge, then phase accumulate, sine table read, duty multiply, compare multiply
// and state update. The state machine handles one item at a time and takes the
// next one only in the idle cycle after the state update, so it never takes a
// new item before it is done with the last one. The result register lets a new
// item enter while the previous result waits on the output; the state update
// of that item then holds until the waiting result has been taken.
module spwm_channel_blanking
    import spwm_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [31:0]       i_cfg_data,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    // dt_us, master_enable, channel, channel_present, channel_enable,
    // channel_faulted, mod_index, commit_ok, zero fill
    input  wire logic [IN_W-1:0]   s_axis_tdata,
    // first_of_tick
    input  wire logic              s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    // out_channel, cmp_value, pwm_forced_low, direction_high,
    // stage_enabled, blanking_active, zero fill
    output logic [OUT_W-1:0]       m_axis_tdata
);
    t_cmd    w_cmd;
    t_status w_status;

    spwm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    spwm_dp #(.CHANNELS(CHANNELS), .SINE_ENTRIES(SINE_ENTRIES)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (s_axis_tdata),
        .i_in_first (s_axis_tuser),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_out_ready(m_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .o_out_data (m_axis_tdata)
    );
endmodule
`default_nettype wire

// ===== tb/sv/tb_spwm_channel_blanking.sv =====
// testbench for spwm_channel_blanking: directed and random channel requests,
// results checked against a local model of the pwm, sine table and blanking logic
// depends on spwm_pkg and the spwm_channel_blanking rtl
`default_nettype none

class spwm_scoreboard;
    bit [15:0] carrier_period;
    bit [15:0] max_mod;
    bit [31:0] phase_step;
    bit [19:0] blanking_us;
    bit [31:0] phase_acc;
    bit        en [6];
    bit        dir [6];
    bit        blank [6];
    bit        pend [6];
    int        blank_left [6];
    bit [15:0] duty_q [6];
    bit [23:0] pending_q [$];
    int        errors;
    int        checked;
    int        blank_seen;
    int        active_seen;

    function void reset_state();
        carrier_period = 500;
        max_mod = 62259;
        phase_step = 214748;
        blanking_us = 1000;
        phase_acc = 0;
        for (int c = 0; c < 6; c++) clear_ch(c);
    endfunction

    function void clear_ch(int c);
        en[c] = 0;
        dir[c] = 0;
        blank[c] = 0;
        pend[c] = 0;
        blank_left[c] = 0;
        duty_q[c] = 0;
    endfunction

    function void write_reg(spwm_pkg::t_reg idx, bit [31:0] val);
        case (idx)
            spwm_pkg::REG_PERIOD:     carrier_period = val[15:0];
            spwm_pkg::REG_MAX_MOD:    max_mod = val[15:0];
            spwm_pkg::REG_PHASE_STEP: phase_step = val;
            spwm_pkg::REG_BLANKING:   blanking_us = val[19:0];
            default: ;
        endcase
    endfunction

    function bit [15:0] sine_mag(bit [31:0] k);
        bit [63:0] x, sum, term, mag;
        x = (64'(k) * 64'd1686629713) / 64'd1024;
        sum = x;
        term = x;
        for (int n = 1; n <= 6; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum = (term > sum) ? 64'd0 : sum - term;
            else sum = sum + term;
        end
        mag = (sum * 64'd65535 + 64'd536870912) >> 30;
        return (mag > 64'd65535) ? 16'hffff : mag[15:0];
    endfunction

    function bit [23:0] pack(bit [2:0] ch, bit [15:0] cmp, bit frc, bit d, bit st, bit bl);
        return {bl, st, d, frc, cmp, ch};
    endfunction

    // compute the result of one accepted item and queue it
    function void note_request(bit [47:0] data, bit first);
        bit [19:0] dt;
        bit ge, pres, cen, flt, cok, pos, enable, d;
        bit [2:0] ch;
        bit [15:0] mi, mag;
        bit [31:0] p, idx, dty;
        bit [63:0] cmp;
        bit [23:0] res;
        int c;
        dt = data[19:0];
        ge = data[20];
        ch = data[23:21];
        pres = data[24];
        cen = data[25];
        flt = data[26];
        mi = data[42:27];
        cok = data[43];
        c = ch;
        if (dt == 0) begin
            for (int i = 0; i < 6; i++) clear_ch(i);
            pending_q.push_back(pack(ch, 0, 1, 0, 0, 0));
            return;
        end
        if (first) phase_acc = phase_acc + phase_step * 32'(dt);
        pos = phase_acc < 32'h8000_0000;
        p = phase_acc & 32'h3fff_ffff;
        if (phase_acc[30]) p = 32'h3fff_ffff - p;
        idx = 32'((64'(p) * 64'd1024) >> 30);
        mag = sine_mag(idx);
        if (c >= 6 || !pres) begin
            pending_q.push_back(pack(ch, 0, 1, 0, 0, 0));
            return;
        end
        enable = ge && cen && !flt && mi > 0;
        dty = enable ? (32'(mi) * 32'(mag)) >> 16 : 0;
        if (dty > max_mod) dty = max_mod;
        cmp = (64'(dty) * 64'(carrier_period)) >> 16;
        if (!enable || cmp == 0 || cmp >= carrier_period) begin
            clear_ch(c);
            pending_q.push_back(pack(ch, 0, 1, 0, 0, 0));
            return;
        end
        if (blank[c]) begin
            if (pos != pend[c]) begin
                pend[c] = pos;
                blank_left[c] = blanking_us;
            end
            blank_left[c] -= int'(dt);
            if (blank_left[c] > 0) begin
                duty_q[c] = 0;
                en[c] = 0;
                blank_seen++;
                pending_q.push_back(pack(ch, 0, 1, dir[c], 0, 1));
                return;
            end
            d = pend[c];
        end else if (en[c] && pos != dir[c]) begin
            pend[c] = pos;
            blank_left[c] = blanking_us;
            duty_q[c] = 0;
            en[c] = 0;
            blank[c] = 1;
            blank_seen++;
            pending_q.push_back(pack(ch, 0, 1, dir[c], 0, 1));
            return;
        end else begin
            d = pos;
        end
        if (!en[c] && !cok) begin
            clear_ch(c);
            pending_q.push_back(pack(ch, 0, 1, 0, 0, 0));
            return;
        end
        duty_q[c] = dty[15:0];
        dir[c] = d;
        en[c] = 1;
        blank[c] = 0;
        active_seen++;
        pending_q.push_back(pack(ch, cmp[15:0], 0, d, 1, 0));
    endfunction

    function void check_result(bit [23:0] got);
        bit [23:0] exp_r;
        checked++;
        if (pending_q.size() == 0) begin
            $error("result %h with no item outstanding", got);
            errors++;
            return;
        end
        exp_r = pending_q.pop_front();
        if (got[2:0] !== exp_r[2:0]) begin
            $error("out_channel exp %0d got %0d", exp_r[2:0], got[2:0]); errors++;
        end
        if (got[18:3] !== exp_r[18:3]) begin
            $error("cmp_value exp %0d got %0d", exp_r[18:3], got[18:3]); errors++;
        end
        if (got[19] !== exp_r[19]) begin
            $error("pwm_forced_low exp %0d got %0d", exp_r[19], got[19]); errors++;
        end
        if (got[20] !== exp_r[20]) begin
            $error("direction_high exp %0d got %0d", exp_r[20], got[20]); errors++;
        end
        if (got[21] !== exp_r[21]) begin
            $error("stage_enabled exp %0d got %0d", exp_r[21], got[21]); errors++;
        end
        if (got[22] !== exp_r[22]) begin
            $error("blanking_active exp %0d got %0d", exp_r[22], got[22]); errors++;
        end
    endfunction
endclass

module tb_spwm_channel_blanking;
    import spwm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [23:0] m_axis_tdata;

    spwm_scoreboard sb;
    int  idle_cycles;
    bit  long_hold;
    bit  timed_out;

    always #4 i_clk = ~i_clk;

    spwm_channel_blanking dut (.*);

    // receiver: own stall pattern plus an on-demand long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 0;
        end else if (long_hold) begin
            m_axis_tready <= 0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("stall watchdog expired");
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_request(bit [19:0] dt, bit first, bit ge, bit [2:0] ch, bit pres,
                                bit cen, bit flt, bit [15:0] mi, bit cok);
        bit [47:0] d;
        d = {4'b0, cok, mi, flt, cen, pres, ch, ge, dt};
        s_axis_tvalid <= 1;
        s_axis_tdata <= d;
        s_axis_tuser <= first;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(d, first);
    endtask

    task automatic pause_sender();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_reg idx, bit [31:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.write_reg(idx, val);
    endtask

    // well-formed tick: one first_of_tick request then a few channels
    task automatic random_tick(int nch);
        bit [19:0] dt;
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) dt = 0;
        else if (r == 1) dt = 20'($urandom_range(1, 1000000));
        else if (r == 2) dt = 20'hfffff;
        else dt = 20'($urandom_range(50, 2000));
        for (int i = 0; i < nch; i++) begin
            send_request(dt, i == 0, $urandom_range(0, 15) != 0,
                         ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                     : 3'($urandom_range(0, 5)),
                         $urandom_range(0, 15) != 0, $urandom_range(0, 9) != 0,
                         $urandom_range(0, 15) == 0,
                         ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(20000, 65535)),
                         $urandom_range(0, 5) != 0);
            if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 8)) pause_sender();
        end
    endtask

    initial begin
        int sent;
        sb = new();
        sb.reset_state();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: extremes, invalid tick, absent and out of range channel
        send_request(20'd100, 1, 1, 3'd0, 1, 1, 0, 16'hffff, 1);
        send_request(20'd100, 0, 1, 3'd5, 1, 1, 0, 16'hffff, 1);
        send_request(20'd100, 0, 1, 3'd7, 1, 1, 0, 16'hffff, 1);
        send_request(20'd100, 0, 1, 3'd1, 0, 1, 0, 16'hffff, 1);
        send_request(20'd100, 0, 0, 3'd2, 1, 1, 0, 16'hffff, 1);
        send_request(20'd100, 0, 1, 3'd2, 1, 1, 1, 16'hffff, 1);
        send_request(20'd100, 0, 1, 3'd3, 1, 1, 0, 16'd0, 1);
        send_request(20'd100, 0, 1, 3'd4, 1, 1, 0, 16'hffff, 0);
        send_request(20'd0, 1, 1, 3'd0, 1, 1, 0, 16'hffff, 1);
        send_request(20'hfffff, 1, 1, 3'd0, 1, 1, 0, 16'hffff, 1);
        // walk channel 0 across half waves to hit blanking and its restart
        for (int i = 0; i < 14; i++)
            send_request(20'd2500, 1, 1, 3'd0, 1, 1, 0, 16'hc000, 1);
        wait_drained();

        cfg_write(REG_PERIOD, 32'd2);
        cfg_write(REG_MAX_MOD, 32'd65535);
        cfg_write(REG_PHASE_STEP, 32'hffff_ffff);
        cfg_write(REG_BLANKING, 32'd0);
        sent = 0;
        for (int ph = 0; ph < 5; ph++) begin
            while (sent < (ph + 1) * 315) begin
                int n;
                n = $urandom_range(1, 6);
                random_tick(n);
                sent += n;
                if (sent > 600 && sent < 640 && !long_hold) begin
                    long_hold = 1;
                    fork
                        begin
                            repeat (300) @(posedge i_clk);
                            long_hold = 0;
                        end
                    join_none
                end
            end
            wait_drained();
            case (ph)
                0: begin
                    cfg_write(REG_PERIOD, 32'd65535);
                    cfg_write(REG_MAX_MOD, 32'd0);
                    cfg_write(REG_PHASE_STEP, 32'd0);
                    cfg_write(REG_BLANKING, 32'd1000000);
                end
                1: begin
                    cfg_write(REG_PERIOD, 32'd500);
                    cfg_write(REG_MAX_MOD, 32'd62259);
                    cfg_write(REG_PHASE_STEP, 32'd214748);
                    cfg_write(REG_BLANKING, 32'd1000);
                end
                2: begin
                    cfg_write(REG_PERIOD, 32'($urandom_range(2, 65535)));
                    cfg_write(REG_MAX_MOD, 32'($urandom_range(30000, 65535)));
                    cfg_write(REG_PHASE_STEP, 32'($urandom_range(50000, 5000000)));
                    cfg_write(REG_BLANKING, 32'($urandom_range(0, 3000)));
                end
                default: begin
                    cfg_write(REG_PERIOD, 32'd1000);
                    cfg_write(REG_MAX_MOD, 32'd65535);
                    cfg_write(REG_PHASE_STEP, 32'd1000000);
                    cfg_write(REG_BLANKING, 32'd500);
                end
            endcase
        end
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.pending_q.size() != 0) begin
            $error("%0d results never arrived", sb.pending_q.size());
            sb.errors++;
        end
        $display("checked %0d results: %0d switching, %0d in blanking, five settings",
                 sb.checked, sb.active_seen, sb.blank_seen);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
sv/spwm_pkg.sv
sv/spwm_sine_rom.sv
sv/spwm_ctrl.sv
sv/spwm_dp.sv
sv/spwm_channel_blanking.sv
tb/sv/tb_spwm_channel_blanking.sv
